// ===== design/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray/box slab intersect block
// Holds the fixed-point defaults, pipeline depths and the per-axis lane result.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int NUM_AXES      = 3;
    localparam int WORD_W        = 32;
    localparam int NUM_REGS      = 6;
    localparam int ADDR_W        = 5;

    // divider: one magnitude stage, 32 quotient-bit stages, one saturation stage
    localparam int DIV_LAT  = 34;
    // lane: divider plus one ordering stage
    localparam int LANE_LAT = DIV_LAT + 1;

    localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    // register indexes
    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_MAX_X = 3'd3;
    localparam logic [2:0] REG_MAX_Y = 3'd4;
    localparam logic [2:0] REG_MAX_Z = 3'd5;

    // what one axis lane reports to the merge stage
    typedef struct packed {
        logic signed [WORD_W-1:0] t_near;
        logic signed [WORD_W-1:0] t_far;
        logic                     dir_zero;
        logic                     in_slab;
    } lane_res_t;

endpackage

// ===== design/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div: pipelined slab distance divider
// Computes sat32(((plane - org) << FRAC_BITS) / dir), truncated toward zero,
// one quotient bit per stage on magnitudes.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::DEF_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [31:0]       plane,
    input  logic signed [31:0]       org,
    input  logic signed [31:0]       dir,
    output logic signed [31:0]       t_dist
);

    localparam int NW = 33 + FRAC_BITS;
    localparam int HW = NW - 32;

    logic signed [32:0] diff;
    logic        [32:0] diff_abs;
    logic        [NW-1:0] num_mag;
    logic        [31:0] den_mag;
    logic        [HW-1:0] num_hi;

    logic [31:0] rem_reg  [0:32];
    logic [31:0] lo_reg   [0:32];
    logic [31:0] q_reg    [0:32];
    logic [31:0] den_reg  [0:32];
    logic        neg_reg  [0:32];
    logic        ovf_reg  [0:32];
    logic signed [31:0] dist_reg;
    logic signed [31:0] dist_next;

    // take magnitudes and split the numerator
    always_comb begin
        diff     = {plane[31], plane} - {org[31], org};
        diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
        num_mag  = {diff_abs, {FRAC_BITS{1'b0}}};
        den_mag  = dir[31] ? 32'(-dir) : 32'(dir);
        num_hi   = num_mag[NW-1:32];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= 32'(num_hi);
            lo_reg[0]  <= num_mag[31:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den_mag;
            neg_reg[0] <= diff[32] ^ dir[31];
            ovf_reg[0] <= 33'(num_hi) >= {1'b0, den_mag};
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= 32; k++) begin : g_bit
        logic [32:0] trial;
        logic        ge;
        always_comb begin
            trial = {rem_reg[k-1], lo_reg[k-1][31]};
            ge    = trial >= {1'b0, den_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? 32'(trial - {1'b0, den_reg[k-1]}) : trial[31:0];
                lo_reg[k]  <= {lo_reg[k-1][30:0], 1'b0};
                q_reg[k]   <= {q_reg[k-1][30:0], ge};
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    // apply sign and saturate
    always_comb begin
        priority if (ovf_reg[32]) begin
            dist_next = neg_reg[32] ? rbsi_pkg::SAT_MIN : rbsi_pkg::SAT_MAX;
        end else if (!neg_reg[32]) begin
            dist_next = q_reg[32][31] ? rbsi_pkg::SAT_MAX : $signed(q_reg[32]);
        end else if (q_reg[32] > 32'h8000_0000) begin
            dist_next = rbsi_pkg::SAT_MIN;
        end else begin
            dist_next = $signed(32'(-q_reg[32]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign t_dist = dist_reg;

endmodule

// ===== design/rbsi_lane.sv =====
// ----------------------------------------------------------------------------
// rbsi_lane: one axis of the slab test
// Two dividers for the near and far planes, a delay line for the zero
// direction case, and a final stage that orders the two distances.
// ----------------------------------------------------------------------------
module rbsi_lane #(
    parameter int FRAC_BITS = rbsi_pkg::DEF_FRAC_BITS
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [31:0]  org,
    input  logic signed [31:0]  dir,
    input  logic signed [31:0]  box_lo,
    input  logic signed [31:0]  box_hi,
    output rbsi_pkg::lane_res_t res
);

    localparam int DL = rbsi_pkg::DIV_LAT;

    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
    logic [1:0]         flag_reg [0:DL-1];
    rbsi_pkg::lane_res_t res_reg;
    rbsi_pkg::lane_res_t res_next;

    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
        .aclk (aclk), .en (en), .plane (box_lo), .org (org), .dir (dir), .t_dist (t_lo)
    );

    rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
        .aclk (aclk), .en (en), .plane (box_hi), .org (org), .dir (dir), .t_dist (t_hi)
    );

    // carry zero-direction and in-slab flags alongside the dividers
    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg[0] <= {dir == '0, (org >= box_lo) && (org <= box_hi)};
            for (int i = 1; i < DL; i++) begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    // order near and far
    always_comb begin
        res_next.t_near   = (t_lo > t_hi) ? t_hi : t_lo;
        res_next.t_far    = (t_lo > t_hi) ? t_lo : t_hi;
        res_next.dir_zero = flag_reg[DL-1][1];
        res_next.in_slab  = flag_reg[DL-1][0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/rbsi_merge.sv =====
// ----------------------------------------------------------------------------
// rbsi_merge: combine the axis lanes into one result word
// Raises the entry, lowers the exit, checks the zero-direction slabs and
// drives the output register.
// ----------------------------------------------------------------------------
module rbsi_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  rbsi_pkg::lane_res_t lane [0:rbsi_pkg::NUM_AXES-1],
    input  logic signed [31:0]  t_start,
    input  logic signed [31:0]  t_end,
    output logic                out_valid,
    output logic                out_hit,
    output logic signed [31:0]  out_enter,
    output logic signed [31:0]  out_exit
);

    logic               vld_a_reg;
    logic signed [31:0] t0_reg, t0_next;
    logic signed [31:0] t1_reg, t1_next;
    logic               ok_reg, ok_next;
    logic               vld_reg;
    logic               hit_reg, hit_next;
    logic signed [31:0] enter_reg;
    logic signed [31:0] exit_reg;

    // narrow the interval over the bounded axes
    always_comb begin
        t0_next = t_start;
        t1_next = t_end;
        ok_next = 1'b1;
        for (int i = 0; i < rbsi_pkg::NUM_AXES; i++) begin
            if (lane[i].dir_zero) begin
                if (!lane[i].in_slab) ok_next = 1'b0;
            end else begin
                if (lane[i].t_near > t0_next) t0_next = lane[i].t_near;
                if (lane[i].t_far < t1_next) t1_next = lane[i].t_far;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t0_reg <= t0_next;
            t1_reg <= t1_next;
            ok_reg <= ok_next;
        end
    end

    // final hit decision into the output register
    assign hit_next = ok_reg && (t0_reg <= t1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg   <= hit_next;
            enter_reg <= hit_next ? t0_reg : '0;
            exit_reg  <= hit_next ? t1_reg : '0;
        end
    end

    assign out_valid = vld_reg;
    assign out_hit   = hit_reg;
    assign out_enter = enter_reg;
    assign out_exit  = exit_reg;

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_hit |-> out_enter == '0 && out_exit == '0)
        else $error("miss with nonzero distances");

    a_hit_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_hit |-> out_enter <= out_exit)
        else $error("hit with entry beyond exit");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

// ===== design/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray versus axis-aligned box slab test
// Each input word passes through the axis lanes, whose depth is set by the
// 32-stage quotient pipeline, and then through the merge to a result word.
// Throughput: one word per cycle; the whole pipeline holds while a result
// waits. Reset (aresetn low, synchronous) clears valid state and box to 0.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbsi_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_t_start, ray_t_end
    input  logic [255:0]                  s_tdata,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, t_enter, t_exit, 7 zero bits
    output logic [71:0]                   m_tdata,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbsi_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int NA = rbsi_pkg::NUM_AXES;
    localparam int LL = rbsi_pkg::LANE_LAT;

    logic signed [31:0] box_lo_reg [0:NA-1];
    logic signed [31:0] box_hi_reg [0:NA-1];
    logic [2:0]         reg_idx;
    logic               en;
    logic               vld_reg [0:LL-1];
    logic signed [31:0] ts_reg  [0:LL-1];
    logic signed [31:0] te_reg  [0:LL-1];
    rbsi_pkg::lane_res_t lane_res [0:NA-1];
    logic               out_hit;
    logic signed [31:0] out_enter;
    logic signed [31:0] out_exit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NA; i++) begin
                box_lo_reg[i] <= '0;
                box_hi_reg[i] <= '0;
            end
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                rbsi_pkg::REG_MIN_X: box_lo_reg[0] <= pwdata;
                rbsi_pkg::REG_MIN_Y: box_lo_reg[1] <= pwdata;
                rbsi_pkg::REG_MIN_Z: box_lo_reg[2] <= pwdata;
                rbsi_pkg::REG_MAX_X: box_hi_reg[0] <= pwdata;
                rbsi_pkg::REG_MAX_Y: box_hi_reg[1] <= pwdata;
                rbsi_pkg::REG_MAX_Z: box_hi_reg[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            rbsi_pkg::REG_MIN_X: prdata = box_lo_reg[0];
            rbsi_pkg::REG_MIN_Y: prdata = box_lo_reg[1];
            rbsi_pkg::REG_MIN_Z: prdata = box_lo_reg[2];
            rbsi_pkg::REG_MAX_X: prdata = box_hi_reg[0];
            rbsi_pkg::REG_MAX_Y: prdata = box_hi_reg[1];
            rbsi_pkg::REG_MAX_Z: prdata = box_hi_reg[2];
            default:             prdata = '0;
        endcase
    end

    // advance the pipeline unless a result is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // carry valid and interval alongside the lanes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LL; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < LL; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ts_reg[0] <= s_tdata[223:192];
            te_reg[0] <= s_tdata[255:224];
            for (int i = 1; i < LL; i++) begin
                ts_reg[i] <= ts_reg[i-1];
                te_reg[i] <= te_reg[i-1];
            end
        end
    end

    for (genvar a = 0; a < NA; a++) begin : g_lane
        rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk   (aclk),
            .en     (en),
            .org    (s_tdata[32*a +: 32]),
            .dir    (s_tdata[32*(a+NA) +: 32]),
            .box_lo (box_lo_reg[a]),
            .box_hi (box_hi_reg[a]),
            .res    (lane_res[a])
        );
    end

    rbsi_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[LL-1]),
        .lane      (lane_res),
        .t_start   (ts_reg[LL-1]),
        .t_end     (te_reg[LL-1]),
        .out_valid (m_tvalid),
        .out_hit   (out_hit),
        .out_enter (out_enter),
        .out_exit  (out_exit)
    );

    assign m_tdata = {7'b0, out_exit, out_enter, out_hit};

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: ray/box slab intersect stream check
// Drives rays through the input stream, predicts hit/enter/exit per word from
// a behavioral slab test, and checks every result word in order. The box is
// rewritten over APB between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = rbsi_pkg::DEF_FRAC_BITS;
    localparam int NAX      = rbsi_pkg::NUM_AXES;
    localparam int SETTLE   = 60;
    localparam int CYC_MAX  = 400000;

    typedef struct packed {
        logic signed [31:0] t_end;
        logic signed [31:0] t_start;
        logic signed [31:0] dz;
        logic signed [31:0] dy;
        logic signed [31:0] dx;
        logic signed [31:0] oz;
        logic signed [31:0] oy;
        logic signed [31:0] ox;
    } ray_t;

    typedef struct packed {
        logic [6:0]         pad;
        logic signed [31:0] t_exit;
        logic signed [31:0] t_enter;
        logic               hit;
    } hit_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_t_start, ray_t_end
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // hit, t_enter, t_exit, 7 zero bits
    logic [71:0]  m_tdata;
    logic         psel, penable, pwrite;
    logic [rbsi_pkg::ADDR_W-1:0] paddr;
    logic [31:0]  pwdata, prdata;
    logic         pready;

    ray_box_slab_intersect u_dut (.*);

    // box copy used by the predictor
    logic signed [31:0] box_lo [NAX];
    logic signed [31:0] box_hi [NAX];

    hit_t expected_hits [$];
    int   mismatches;
    int   cycles;
    int   rx_wait;
    bit   hold_off;
    bit   failed;

    initial begin
        aclk = 0;
    end
    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [31:0] sat_word(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return rbsi_pkg::SAT_MAX;
        if (v < -64'sh8000_0000) return rbsi_pkg::SAT_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] plane_dist(logic signed [31:0] plane,
            logic signed [31:0] org, logic signed [31:0] dir);
        logic signed [63:0] num;
        num = (64'(plane) - 64'(org)) * (64'sd1 <<< FRAC);
        return sat_word(num / 64'(dir));
    endfunction

    // slab test of one ray against the current box
    function automatic hit_t slab_hit(ray_t r);
        hit_t res;
        logic signed [31:0] org [NAX];
        logic signed [31:0] dir [NAX];
        logic signed [31:0] t0, t1, tn, tf, sw;
        bit ok;
        org = '{r.ox, r.oy, r.oz};
        dir = '{r.dx, r.dy, r.dz};
        t0 = r.t_start;
        t1 = r.t_end;
        ok = 1;
        for (int a = 0; a < NAX; a++) begin
            if (dir[a] == 0) begin
                if (org[a] < box_lo[a] || org[a] > box_hi[a]) ok = 0;
            end else begin
                tn = plane_dist(box_lo[a], org[a], dir[a]);
                tf = plane_dist(box_hi[a], org[a], dir[a]);
                if (tn > tf) begin
                    sw = tn; tn = tf; tf = sw;
                end
                if (tn > t0) t0 = tn;
                if (tf < t1) t1 = tf;
            end
            if (t0 > t1) ok = 0;
        end
        res = '0;
        if (ok) begin
            res.hit = 1;
            res.t_enter = t0;
            res.t_exit = t1;
        end
        return res;
    endfunction

    // setup then access; the bus is released by the caller
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= rbsi_pkg::ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        if (idx < NAX) box_lo[idx] = val;
        else box_hi[idx - NAX] = val;
    endtask

    task automatic load_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        write_reg(rbsi_pkg::REG_MIN_X, lx); write_reg(rbsi_pkg::REG_MIN_Y, ly);
        write_reg(rbsi_pkg::REG_MIN_Z, lz); write_reg(rbsi_pkg::REG_MAX_X, hx);
        write_reg(rbsi_pkg::REG_MAX_Y, hy); write_reg(rbsi_pkg::REG_MAX_Z, hz);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // hand one word to the block and queue its prediction
    task automatic send_ray(ray_t r, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= r;
        do @(posedge aclk); while (!s_tready);
        expected_hits.push_back(slab_hit(r));
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 0;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        r.ox = rand_coord(); r.oy = rand_coord(); r.oz = rand_coord();
        r.dx = rand_coord(); r.dy = rand_coord(); r.dz = rand_coord();
        if ($urandom_range(0, 2) != 0) begin
            // well-formed: origin near the box, modest direction
            r.ox = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            r.oy = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            r.oz = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
            r.dx = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            r.dy = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            r.dz = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            if ($urandom_range(0, 5) == 0) r.dy = 0;
            r.t_start = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
            r.t_end = 32'($urandom_range(0, 64 << 16));
        end else begin
            r.t_start = rand_coord();
            r.t_end = rand_coord();
        end
        return r;
    endfunction

    // receiver: draw a wait per word, plus one long hold-off on request
    always @(posedge aclk) begin
        int w;
        if (!aresetn || hold_off) begin
            m_tready <= 0;
            rx_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            w = $urandom_range(0, 17);
            rx_wait <= w;
            m_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1;
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge aclk) begin
        hit_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
            end else begin
                want = expected_hits.pop_front();
                if (got.hit !== want.hit || got.t_enter !== want.t_enter
                        || got.t_exit !== want.t_exit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want hit=%0b enter=%h exit=%h, got hit=%0b enter=%h exit=%h",
                            want.hit, want.t_enter, want.t_exit,
                            got.hit, got.t_enter, got.t_exit);
                end
            end
        end
    end

    typedef struct {
        ray_t r;
        bit   known;
        hit_t res;
    } vec_t;

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        vec_t vecs [$];
        vec_t v;
        ray_t r;
        mismatches = 0;
        cycles = 0;
        hold_off = 0;
        aresetn = 0;
        s_tvalid = 0; s_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        for (int a = 0; a < NAX; a++) begin
            box_lo[a] = 0; box_hi[a] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed rows, reset box (point at origin)
        r = '0; r.t_end = ONE;
        v.r = r; v.known = 1; v.res = '{pad: 0, hit: 1, t_enter: 0, t_exit: ONE};
        vecs.push_back(v);
        r.ox = ONE;
        v.r = r; v.res = '0;
        vecs.push_back(v);
        r = '0; r.t_start = ONE; r.t_end = 0;
        v.r = r; v.res = '0;
        vecs.push_back(v);
        foreach (vecs[i]) begin
            send_ray(vecs[i].r, 0);
            if (vecs[i].known && slab_hit(vecs[i].r) != vecs[i].res) begin
                mismatches++;
                $display("directed row %0d disagrees with the predictor", i);
            end
        end
        drain();

        // unit box, directed extremes
        load_box(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, ONE, ONE, ONE);
        vecs = {};
        r = '{ox: 32'hFFF6_0000, oy: 0, oz: 0, dx: ONE, dy: 0, dz: 0,
              t_start: 0, t_end: 32'h7FFF_FFFF};
        v.r = r; v.known = 0; vecs.push_back(v);
        r.dx = 32'h0000_0001; vecs.push_back(v);
        v.r = r; vecs.push_back(v);
        r.dx = 32'h8000_0000; v.r = r; vecs.push_back(v);
        r.dx = 32'h7FFF_FFFF; r.ox = 32'h8000_0000; v.r = r; vecs.push_back(v);
        r.ox = 32'h7FFF_FFFF; r.dx = 32'hFFFF_FFFF; v.r = r; vecs.push_back(v);
        r = '{ox: 0, oy: 32'h0002_0000, oz: 0, dx: ONE, dy: 0, dz: ONE,
              t_start: 32'h8000_0000, t_end: 32'h7FFF_FFFF};
        v.r = r; vecs.push_back(v);
        r.oy = ONE; v.r = r; vecs.push_back(v);
        r = '{default: 32'hFFFF_FFFF}; v.r = r; vecs.push_back(v);
        r = '{default: 32'h8000_0000}; v.r = r; vecs.push_back(v);
        r = '{default: 32'h7FFF_FFFF}; v.r = r; vecs.push_back(v);
        foreach (vecs[i]) send_ray(vecs[i].r, 1);
        drain();

        // inverted x axis, extreme corners on the others
        load_box(ONE, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        r = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: ONE, dz: ONE,
              t_start: 0, t_end: ONE};
        send_ray(r, 0);
        r.dx = ONE; send_ray(r, 0);
        for (int i = 0; i < 200; i++) send_ray(rand_ray(), 1);
        drain();

        // back-pressure: stall the receiver while the sender keeps offering
        load_box(32'hFFFC_0000, 32'hFFFE_0000, 32'hFFFF_8000,
                 32'h0003_0000, 32'h0002_0000, 32'h0005_0000);
        fork
            begin
                hold_off = 1;
                repeat (150) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 120; i++) send_ray(rand_ray(), 0);
        join
        drain();
        for (int i = 0; i < 300; i++) send_ray(rand_ray(), 1);
        drain();

        // random box, random rays
        load_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        for (int i = 0; i < 100; i++) send_ray(rand_ray(), 1);
        drain();
        load_box(32'hFFF8_0000, 32'hFFF8_0000, 32'hFFF8_0000,
                 32'h0008_0000, 32'h0008_0000, 32'h0008_0000);
        for (int i = 0; i < 210; i++) send_ray(rand_ray(), $urandom_range(0, 1));
        drain();

        failed = mismatches != 0 || expected_hits.size() != 0;
        if (!failed) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/rbsi_pkg.sv
design/rbsi_div.sv
design/rbsi_lane.sv
design/rbsi_merge.sv
design/ray_box_slab_intersect.sv
test/testbench.sv
